### design/i2cm_pkg.sv
// Shared item types and constants for the I2C byte-transaction master.
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;
	localparam logic [7:0]  POLL_LIMIT        = 8'd200;

	typedef struct packed {
		logic       request;
		logic       op;
		logic [7:0] device_byte;
		logic [7:0] write_byte;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_missing;
	} rsp_t;

endpackage

### design/i2cm_seq.sv
// Tick-driven I2C transaction sequencer: line levels, shift registers, ack polling.
`timescale 1ns / 1ps

module i2cm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  i2cm_pkg::cmd_t     cmd,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	output i2cm_pkg::rsp_t     rsp_next
);

	typedef enum logic [5:0] {
		ST_IDLE      = 6'd0,
		ST_START_SDA = 6'd1,
		ST_START_SCL = 6'd2,
		ST_START_LOW = 6'd3,
		DEV_SCL_LOW  = 6'd4,
		DEV_BIT      = 6'd5,
		DEV_CLK_HI   = 6'd6,
		DEV_CLK_LO   = 6'd7,
		DEV_REL      = 6'd8,
		DEV_WAIT     = 6'd9,
		DEV_ACK_HI   = 6'd10,
		DEV_POLL     = 6'd11,
		DEV_ACK_LO   = 6'd12,
		DEV_NEXT     = 6'd13,
		DAT_SCL_LOW  = 6'd20,
		DAT_BIT      = 6'd21,
		DAT_CLK_HI   = 6'd22,
		DAT_CLK_LO   = 6'd23,
		DAT_REL      = 6'd24,
		DAT_WAIT     = 6'd25,
		DAT_ACK_HI   = 6'd26,
		DAT_POLL     = 6'd27,
		DAT_ACK_LO   = 6'd28,
		DAT_NEXT     = 6'd29,
		RD_INIT      = 6'd32,
		RD_LO        = 6'd33,
		RD_HI        = 6'd34,
		RD_SAMPLE    = 6'd35,
		RD_STORE     = 6'd36,
		NAK_LO       = 6'd37,
		NAK_SDA      = 6'd38,
		NAK_HI       = 6'd39,
		NAK_END      = 6'd40,
		STOP_SDA     = 6'd48,
		STOP_HI      = 6'd49,
		STOP_REL     = 6'd50,
		ST_DONE      = 6'd51
	} step_t;

	step_t       step_q, n_step;
	logic [15:0] phase_q;
	logic [15:0] delay_q, n_delay;
	logic [2:0]  bit_q, n_bit;
	logic [7:0]  shift_q, n_shift;
	logic [7:0]  rx_q, n_rx;
	logic        op_q, n_op;
	logic [7:0]  data_q, n_data;
	logic [7:0]  poll_q, n_poll;
	logic [7:0]  poll_inc;
	logic        fail_q, n_fail;
	logic        scl_q, n_scl;
	logic        sda_q, n_sda;
	logic        done;

	always_comb begin
		n_step  = step_q;
		n_delay = delay_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_rx    = rx_q;
		n_op    = op_q;
		n_data  = data_q;
		n_poll  = poll_q;
		n_fail  = fail_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		done    = 1'b0;
		poll_inc = poll_q + 8'd1;

		if (step_q == ST_IDLE && cmd.request) begin
			n_op    = cmd.op;
			n_data  = cmd.write_byte;
			n_shift = cmd.device_byte;
			n_fail  = 1'b0;
			n_poll  = 8'd0;
			n_bit   = 3'd0;
			n_step  = ST_START_SDA;
			n_delay = 16'd0;
		end

		if (n_step != ST_IDLE) begin
			if (n_delay != 16'd0) begin
				n_delay = n_delay - 16'd1;
			end else begin
				n_delay = phase_q;
				case (n_step)
					ST_START_SDA: begin
						n_sda = 1'b1;
						n_step = ST_START_SCL;
					end
					ST_START_SCL: begin
						n_scl = 1'b1;
						n_step = ST_START_LOW;
					end
					ST_START_LOW: begin
						n_sda = 1'b0;
						n_step = DEV_SCL_LOW;
					end
					DEV_SCL_LOW, DAT_SCL_LOW: begin
						n_scl = 1'b0;
						n_bit = 3'd0;
						n_step = step_t'(n_step + 6'd1);
					end
					DEV_BIT, DAT_BIT: begin
						n_sda = n_shift[7];
						n_step = step_t'(n_step + 6'd1);
					end
					DEV_CLK_HI, DAT_CLK_HI: begin
						n_scl = 1'b1;
						n_step = step_t'(n_step + 6'd1);
					end
					DEV_CLK_LO, DAT_CLK_LO: begin
						n_scl = 1'b0;
						n_shift = {n_shift[6:0], 1'b0};
						if (n_bit == 3'd7) begin
							n_step = step_t'(n_step + 6'd1);
						end else begin
							n_bit = n_bit + 3'd1;
							n_step = step_t'(n_step - 6'd2);
						end
					end
					DEV_REL, DAT_REL: begin
						n_sda = 1'b1;
						n_step = step_t'(n_step + 6'd1);
					end
					DEV_WAIT, DAT_WAIT: begin
						n_step = step_t'(n_step + 6'd1);
					end
					DEV_ACK_HI, DAT_ACK_HI: begin
						n_scl = 1'b1;
						n_poll = 8'd0;
						n_step = step_t'(n_step + 6'd1);
					end
					DEV_POLL, DAT_POLL: begin
						if (!cmd.sda_in) begin
							n_step = step_t'(n_step + 6'd1);
						end else begin
							n_poll = poll_inc;
							if (poll_inc >= i2cm_pkg::POLL_LIMIT) begin
								n_fail = 1'b1;
								n_step = step_t'(n_step + 6'd1);
							end else begin
								n_delay = delay_q;
							end
						end
					end
					DEV_ACK_LO, DAT_ACK_LO: begin
						n_scl = 1'b0;
						n_step = step_t'(n_step + 6'd1);
					end
					DEV_NEXT: begin
						if (!n_op) begin
							n_shift = n_data;
							n_step = DAT_SCL_LOW;
						end else begin
							n_step = RD_INIT;
						end
					end
					DAT_NEXT: n_step = STOP_SDA;
					RD_INIT: begin
						n_shift = 8'd0;
						n_bit = 3'd0;
						n_step = RD_LO;
					end
					RD_LO: begin
						n_scl = 1'b0;
						n_step = RD_HI;
					end
					RD_HI: begin
						n_scl = 1'b1;
						n_step = RD_SAMPLE;
					end
					RD_SAMPLE: begin
						n_shift = {n_shift[6:0], cmd.sda_in};
						n_scl = 1'b0;
						if (n_bit == 3'd7) begin
							n_step = RD_STORE;
						end else begin
							n_bit = n_bit + 3'd1;
							n_step = RD_HI;
						end
					end
					RD_STORE: begin
						n_rx = n_shift;
						n_step = NAK_LO;
					end
					NAK_LO: begin
						n_scl = 1'b0;
						n_step = NAK_SDA;
					end
					NAK_SDA: begin
						n_sda = 1'b1;
						n_step = NAK_HI;
					end
					NAK_HI: begin
						n_scl = 1'b1;
						n_step = NAK_END;
					end
					NAK_END: begin
						n_scl = 1'b0;
						n_step = STOP_SDA;
					end
					STOP_SDA: begin
						n_sda = 1'b0;
						n_step = STOP_HI;
					end
					STOP_HI: begin
						n_scl = 1'b1;
						n_step = STOP_REL;
					end
					STOP_REL: begin
						n_sda = 1'b1;
						n_step = ST_DONE;
					end
					ST_DONE: begin
						done = 1'b1;
						n_step = ST_IDLE;
						n_delay = 16'd0;
					end
					default: begin
						n_step = ST_IDLE;
						n_delay = 16'd0;
					end
				endcase
			end
		end
	end

	always_comb begin
		rsp_next.scl_out     = n_scl;
		rsp_next.sda_out     = n_sda;
		rsp_next.sda_drive   = !(n_step inside {[DEV_ACK_HI:DEV_NEXT], [DAT_ACK_HI:DAT_NEXT],
			[RD_LO:RD_STORE]});
		rsp_next.busy_res    = (n_step != ST_IDLE);
		rsp_next.done_res    = done;
		rsp_next.read_byte   = n_rx;
		rsp_next.ack_missing = n_fail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			phase_q <= i2cm_pkg::PHASE_TICKS_RESET;
			delay_q <= 16'd0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			rx_q    <= 8'd0;
			op_q    <= 1'b0;
			data_q  <= 8'd0;
			poll_q  <= 8'd0;
			fail_q  <= 1'b0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				phase_q <= cfg_data;
			end
			if (tick) begin
				step_q  <= n_step;
				delay_q <= n_delay;
				bit_q   <= n_bit;
				shift_q <= n_shift;
				rx_q    <= n_rx;
				op_q    <= n_op;
				data_q  <= n_data;
				poll_q  <= n_poll;
				fail_q  <= n_fail;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tick && step_q == ST_DONE && delay_q == 16'd0 |=> step_q == ST_IDLE)
		else $error("done step did not return to idle");

	a_delay_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		tick && step_q != ST_IDLE && delay_q != 16'd0
		|=> delay_q == $past(delay_q) - 16'd1 && step_q == $past(step_q))
		else $error("hold counter did not count down in place");

	a_fail_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fail_q) |-> $past(step_q) == DEV_POLL || $past(step_q) == DAT_POLL)
		else $error("ack flag set outside a poll step");

	a_poll_bound: assert property (@(posedge clk) disable iff (!arst_n)
		poll_q <= i2cm_pkg::POLL_LIMIT)
		else $error("poll count passed its limit");
`endif

endmodule

### design/i2c_master_byte_transactions.sv
// Top level of the I2C byte-transaction master: handshakes and result register.
`timescale 1ns / 1ps

// Each cmd item is one line-sampling tick and yields exactly one rsp item with the
// line levels, status and received byte after that tick. One item is taken every
// clock; the rsp item appears in the output register on the next cycle. The only
// thing that holds off cmd is a full output register whose rsp is stalled.
// phase_ticks is written through the cfg channel (always ready); the user must write it
// only while no item is in flight, and the block itself does not enforce this.
module i2c_master_byte_transactions (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  i2cm_pkg::cmd_t     cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output i2cm_pkg::rsp_t     rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	logic           accept;
	logic           rsp_valid_q;
	i2cm_pkg::rsp_t rsp_q;
	i2cm_pkg::rsp_t rsp_next;

	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	i2cm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (accept),
		.cmd      (cmd),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.rsp_next (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
